/* design/lr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_pkg
// Shared widths, codes and the line state record of the line rasterizer.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int COORD_BITS = 12;
    localparam int COLOR_BITS = 24;
    localparam int ERR_BITS   = COORD_BITS + 2;

    // input opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // minor axis step codes, the spare code means no movement
    localparam logic [1:0] MINOR_NONE  = 2'd0;
    localparam logic [1:0] MINOR_PLUS  = 2'd1;
    localparam logic [1:0] MINOR_MINUS = 2'd2;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [COLOR_BITS-1:0] t_color;
    typedef logic [ERR_BITS-1:0]   t_err;

    typedef struct packed {
        t_coord     cur_x;
        t_coord     cur_y;
        t_coord     major_end;
        t_coord     major_delta;
        t_coord     minor_delta;
        t_err       error_sum;
        logic       x_is_major;
        logic       major_step_neg;
        logic [1:0] minor_step;
        t_color     held_color;
        logic       active;
    } t_line_state;

endpackage

/* design/lr_setup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_setup
// Builds a fresh line state from two endpoints and a colour: deltas, major
// axis, step directions and a cleared error sum.
// ----------------------------------------------------------------------------
module lr_setup (
    input  lr_pkg::t_coord      i_start_x,
    input  lr_pkg::t_coord      i_start_y,
    input  lr_pkg::t_coord      i_end_x,
    input  lr_pkg::t_coord      i_end_y,
    input  lr_pkg::t_color      i_line_color,
    output lr_pkg::t_line_state o_state
);
    import lr_pkg::*;

    t_coord w_dx;
    t_coord w_dy;

    assign w_dx = (i_start_x >= i_end_x) ? (i_start_x - i_end_x) : (i_end_x - i_start_x);
    assign w_dy = (i_start_y >= i_end_y) ? (i_start_y - i_end_y) : (i_end_y - i_start_y);

    always_comb begin
        o_state            = '0;
        o_state.cur_x      = i_start_x;
        o_state.cur_y      = i_start_y;
        o_state.held_color = i_line_color;
        o_state.active     = 1'b1;
        // ties go to the y axis
        if (w_dx > w_dy) begin
            o_state.x_is_major     = 1'b1;
            o_state.major_delta    = w_dx;
            o_state.minor_delta    = w_dy;
            o_state.major_end      = i_end_x;
            o_state.major_step_neg = (i_end_x < i_start_x);
            o_state.minor_step     = (i_end_y > i_start_y) ? MINOR_PLUS :
                                     (i_end_y < i_start_y) ? MINOR_MINUS : MINOR_NONE;
        end else begin
            o_state.x_is_major     = 1'b0;
            o_state.major_delta    = w_dy;
            o_state.minor_delta    = w_dx;
            o_state.major_end      = i_end_y;
            o_state.major_step_neg = (i_end_y < i_start_y);
            o_state.minor_step     = (i_end_x > i_start_x) ? MINOR_PLUS :
                                     (i_end_x < i_start_x) ? MINOR_MINUS : MINOR_NONE;
        end
    end

endmodule

/* design/lr_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_step
// One rasterizer step: shows the current pixel; at the last one it goes idle,
// else steps the major axis, and the minor one when the error sum overflows.
// ----------------------------------------------------------------------------
module lr_step (
    input  lr_pkg::t_line_state i_state,
    output lr_pkg::t_line_state o_state,
    output lr_pkg::t_coord      o_pixel_x,
    output lr_pkg::t_coord      o_pixel_y,
    output lr_pkg::t_color      o_pixel_color,
    output logic                o_last_pixel
);
    import lr_pkg::*;

    t_coord w_maj;
    t_coord w_mnr;
    t_coord w_maj_next;
    t_coord w_mnr_next;
    t_err   w_err_add;
    t_err   w_major_len;
    logic   w_overflow;

    assign w_maj = i_state.x_is_major ? i_state.cur_x : i_state.cur_y;
    assign w_mnr = i_state.x_is_major ? i_state.cur_y : i_state.cur_x;

    assign o_pixel_x     = i_state.cur_x;
    assign o_pixel_y     = i_state.cur_y;
    assign o_pixel_color = i_state.held_color;
    assign o_last_pixel  = (w_maj == i_state.major_end);

    assign w_err_add   = i_state.error_sum + {2'b00, i_state.minor_delta} + t_err'(1);
    assign w_major_len = {2'b00, i_state.major_delta} + t_err'(1);
    assign w_overflow  = (w_err_add >= w_major_len);

    assign w_maj_next = i_state.major_step_neg ? (w_maj - t_coord'(1)) : (w_maj + t_coord'(1));

    always_comb begin
        w_mnr_next = w_mnr;
        if (w_overflow) begin
            case (i_state.minor_step)
                MINOR_PLUS:  w_mnr_next = w_mnr + t_coord'(1);
                MINOR_MINUS: w_mnr_next = w_mnr - t_coord'(1);
                default:     w_mnr_next = w_mnr;
            endcase
        end
    end

    always_comb begin
        o_state = i_state;
        if (o_last_pixel) begin
            o_state.active = 1'b0;
        end else begin
            o_state.error_sum = w_overflow ? (w_err_add - w_major_len) : w_err_add;
            if (i_state.x_is_major) begin
                o_state.cur_x = w_maj_next;
                o_state.cur_y = w_mnr_next;
            end else begin
                o_state.cur_y = w_maj_next;
                o_state.cur_x = w_mnr_next;
            end
        end
    end

endmodule

/* design/line_rasterizer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rasterizer_core
// Integer line rasterizer: a start beat loads a line, each step beat emits
// one pixel of it with its colour and flags the final endpoint.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------
//  command  | i_valid / o_stall        | opcode, endpoints, line colour
//  pixel    | o_valid / i_stall        | pixel x, y, colour, last flag
//
//  while o_stall is low one beat a cycle is taken; an accepted beat is loaded
//  into the input register, and from there into the line state and the result
//  register, which offers a step beat's pixel.
//  the line state advances in the same cycle the pixel is registered, so
//  consecutive step beats run at full rate unless the pixel side stalls.
//  reset (synchronous, active low) clears the line state and both valids.
//  a stall on the pixel side holds the result and backs up into o_stall
//  once the input register is full.
// ----------------------------------------------------------------------------
module line_rasterizer_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic           i_opcode,
    input  lr_pkg::t_coord i_start_x,
    input  lr_pkg::t_coord i_start_y,
    input  lr_pkg::t_coord i_end_x,
    input  lr_pkg::t_coord i_end_y,
    input  lr_pkg::t_color i_line_color,
    output logic           o_valid,
    input  logic           i_stall,
    output lr_pkg::t_coord o_pixel_x,
    output lr_pkg::t_coord o_pixel_y,
    output lr_pkg::t_color o_pixel_color,
    output logic           o_last_pixel
);
    import lr_pkg::*;

    // input register
    logic        r_in_valid;
    logic        r_in_opcode;
    t_coord      r_in_start_x;
    t_coord      r_in_start_y;
    t_coord      r_in_end_x;
    t_coord      r_in_end_y;
    t_color      r_in_color;

    // line state and result register
    t_line_state r_state;
    t_line_state n_state;
    logic        r_out_valid;
    t_coord      r_out_x;
    t_coord      r_out_y;
    t_color      r_out_color;
    logic        r_out_last;

    t_line_state w_setup_state;
    t_line_state w_step_state;
    t_coord      w_pix_x;
    t_coord      w_pix_y;
    t_color      w_pix_color;
    logic        w_pix_last;
    logic        w_out_free;
    logic        w_proc;
    logic        w_emit;
    logic        w_accept;

    lr_setup u_setup (
        .i_start_x    (r_in_start_x),
        .i_start_y    (r_in_start_y),
        .i_end_x      (r_in_end_x),
        .i_end_y      (r_in_end_y),
        .i_line_color (r_in_color),
        .o_state      (w_setup_state)
    );

    lr_step u_step (
        .i_state       (r_state),
        .o_state       (w_step_state),
        .o_pixel_x     (w_pix_x),
        .o_pixel_y     (w_pix_y),
        .o_pixel_color (w_pix_color),
        .o_last_pixel  (w_pix_last)
    );

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_proc     = r_in_valid && w_out_free;
    assign w_emit     = w_proc && (r_in_opcode == OP_STEP) && r_state.active;
    assign o_stall    = r_in_valid && !w_out_free;
    assign w_accept   = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        if (w_proc) begin
            if (r_in_opcode == OP_START) begin
                n_state = w_setup_state;
            end else if (r_state.active) begin
                n_state = w_step_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_opcode  <= i_opcode;
            r_in_start_x <= i_start_x;
            r_in_start_y <= i_start_y;
            r_in_end_x   <= i_end_x;
            r_in_end_y   <= i_end_y;
            r_in_color   <= i_line_color;
        end
        if (w_emit) begin
            r_out_x     <= w_pix_x;
            r_out_y     <= w_pix_y;
            r_out_color <= w_pix_color;
            r_out_last  <= w_pix_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_pixel_color = r_out_color;
    assign o_last_pixel  = r_out_last;

    // a line only goes idle by emitting its last pixel
    a_idle_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_state.active) |-> (r_out_valid && r_out_last))
        else $error("line went idle without a last pixel");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_pix_last) |=> !r_state.active)
        else $error("line still active after last pixel");

    a_err_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.error_sum <= {2'b00, r_state.major_delta})
        else $error("error sum out of range");

    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_stall)
        else $error("stall with empty input register");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives command beats into line_rasterizer_core and checks every pixel beat
// against a cycle-free line walker kept in a scoreboard. Directed lines come
// first, then random lines (mostly well formed, some cut short or overrun,
// some noise), under varying idle rates on both sides and one long hold-off
// on the pixel side.
// ----------------------------------------------------------------------------
module testbench;
    import lr_pkg::*;

    typedef struct packed {
        logic   opcode;
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
        t_color color;
    } t_command;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_color color;
        logic   last;
    } t_pixel;

    class pixel_scoreboard;
        t_coord     cur_x;
        t_coord     cur_y;
        t_coord     major_end;
        t_coord     major_delta;
        t_coord     minor_delta;
        t_err       err_acc;
        logic       x_major;
        logic       major_neg;
        logic [1:0] minor_dir;
        t_color     color;
        logic       active;
        t_pixel     pixel_q[$];
        int         mismatches;

        function new();
            cur_x       = '0;
            cur_y       = '0;
            major_end   = '0;
            major_delta = '0;
            minor_delta = '0;
            err_acc     = '0;
            x_major     = 1'b0;
            major_neg   = 1'b0;
            minor_dir   = MINOR_NONE;
            color       = '0;
            active      = 1'b0;
            mismatches  = 0;
        endfunction

        task report_mismatch(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            mismatches++;
        endtask

        // returns 1 when the beat loads a line or yields a pixel
        function bit note_command(t_command c);
            t_coord dx;
            t_coord dy;
            t_coord maj;
            t_coord mnr;
            t_err   sum;
            t_pixel p;
            if (c.opcode == OP_START) begin
                dx      = (c.sx >= c.ex) ? c.sx - c.ex : c.ex - c.sx;
                dy      = (c.sy >= c.ey) ? c.sy - c.ey : c.ey - c.sy;
                color   = c.color;
                cur_x   = c.sx;
                cur_y   = c.sy;
                err_acc = '0;
                if (dx > dy) begin
                    x_major     = 1'b1;
                    major_delta = dx;
                    minor_delta = dy;
                    major_end   = c.ex;
                    major_neg   = (c.ex < c.sx);
                    minor_dir   = (c.ey > c.sy) ? MINOR_PLUS :
                                  (c.ey < c.sy) ? MINOR_MINUS : MINOR_NONE;
                end else begin
                    // ties go to y
                    x_major     = 1'b0;
                    major_delta = dy;
                    minor_delta = dx;
                    major_end   = c.ey;
                    major_neg   = (c.ey < c.sy);
                    minor_dir   = (c.ex > c.sx) ? MINOR_PLUS :
                                  (c.ex < c.sx) ? MINOR_MINUS : MINOR_NONE;
                end
                active = 1'b1;
                return 1'b1;
            end
            if (!active) begin
                return 1'b0;
            end
            maj     = x_major ? cur_x : cur_y;
            mnr     = x_major ? cur_y : cur_x;
            p.x     = cur_x;
            p.y     = cur_y;
            p.color = color;
            p.last  = (maj == major_end);
            pixel_q.push_back(p);
            if (p.last) begin
                active = 1'b0;
                return 1'b1;
            end
            // error counts in units of delta + 1
            sum = err_acc + t_err'(minor_delta) + t_err'(1);
            if (sum >= t_err'(major_delta) + t_err'(1)) begin
                if (minor_dir == MINOR_PLUS) begin
                    mnr = mnr + 1'b1;
                end else if (minor_dir == MINOR_MINUS) begin
                    mnr = mnr - 1'b1;
                end
                sum = sum - (t_err'(major_delta) + t_err'(1));
            end
            err_acc = sum;
            maj     = major_neg ? maj - 1'b1 : maj + 1'b1;
            if (x_major) begin
                cur_x = maj;
                cur_y = mnr;
            end else begin
                cur_y = maj;
                cur_x = mnr;
            end
            return 1'b1;
        endfunction

        task check_pixel(t_pixel got);
            t_pixel want;
            if (pixel_q.size() == 0) begin
                report_mismatch($sformatf("pixel x=%0d y=%0d with none pending",
                                          got.x, got.y));
                return;
            end
            want = pixel_q.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
                got.last !== want.last) begin
                report_mismatch($sformatf(
                    "pixel got x=%0d y=%0d c=%06h l=%0b, want x=%0d y=%0d c=%06h l=%0b",
                    got.x, got.y, got.color, got.last,
                    want.x, want.y, want.color, want.last));
            end
        endtask

        function int pending();
            return pixel_q.size();
        endfunction
    endclass

    logic   i_clk        = 1'b0;
    logic   i_rst_n      = 1'b0;
    logic   i_valid      = 1'b0;
    logic   i_opcode     = 1'b0;
    t_coord i_start_x    = '0;
    t_coord i_start_y    = '0;
    t_coord i_end_x      = '0;
    t_coord i_end_y      = '0;
    t_color i_line_color = '0;
    logic   i_stall      = 1'b0;
    logic   o_stall;
    logic   o_valid;
    t_coord o_pixel_x;
    t_coord o_pixel_y;
    t_color o_pixel_color;
    logic   o_last_pixel;

    pixel_scoreboard board;
    int   phase       = 0;
    int   beats_used  = 0;
    logic hold_rx     = 1'b0;
    int   send_idle[3] = '{17, 66, 0};
    int   recv_idle[3] = '{66, 17, 0};

    line_rasterizer_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_line_color  (i_line_color),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // pixel side: random stall, plus the long hold-off
    always @(negedge i_clk) begin
        i_stall <= hold_rx || ($urandom_range(99) < recv_idle[phase]);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_pixel({o_pixel_x, o_pixel_y, o_pixel_color, o_last_pixel});
        end
    end

    // hold the pixel side long enough for the core to back up into o_stall
    initial begin
        wait (phase == 2);
        repeat (30) @(posedge i_clk);
        hold_rx = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("line_rasterizer_core: mismatch");
        $finish;
    end

    function automatic t_command random_command();
        t_command c;
        c.opcode = logic'($urandom_range(1));
        c.sx     = t_coord'($urandom);
        c.sy     = t_coord'($urandom);
        c.ex     = t_coord'($urandom);
        c.ey     = t_coord'($urandom);
        c.color  = t_color'($urandom);
        return c;
    endfunction

    function automatic t_coord near(t_coord base);
        int v;
        v = int'(base) + int'($urandom_range(40)) - 20;
        if (v < 0) begin
            v = 0;
        end else if (v > 4095) begin
            v = 4095;
        end
        return t_coord'(v);
    endfunction

    // entered and left just after a falling edge
    task automatic send_command(input t_command c);
        while ($urandom_range(99) < send_idle[phase]) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_opcode     <= c.opcode;
        i_start_x    <= c.sx;
        i_start_y    <= c.sy;
        i_end_x      <= c.ex;
        i_end_y      <= c.ey;
        i_line_color <= c.color;
        do @(posedge i_clk); while (o_stall);
        if (board.note_command(c)) begin
            beats_used++;
        end
        @(negedge i_clk);
    endtask

    task automatic send_start(input t_coord sx, input t_coord sy, input t_coord ex,
                              input t_coord ey, input t_color color);
        t_command c;
        c.opcode = OP_START;
        c.sx     = sx;
        c.sy     = sy;
        c.ex     = ex;
        c.ey     = ey;
        c.color  = color;
        send_command(c);
    endtask

    // steps carry junk in the endpoint fields, which must be ignored
    task automatic send_steps(input int n);
        t_command c;
        repeat (n) begin
            c        = random_command();
            c.opcode = OP_STEP;
            send_command(c);
        end
    endtask

    task automatic random_line();
        t_command c;
        int       len;
        int       n;
        c        = random_command();
        c.opcode = OP_START;
        case ($urandom_range(9))
            0: begin
                // far endpoints, walked only part of the way
            end
            1: begin
                c.sx = $urandom_range(1) ? '1 : '0;
                c.sy = $urandom_range(1) ? '1 : '0;
                c.ex = near(c.sx);
                c.ey = near(c.sy);
            end
            2: begin
                c.ex = $urandom_range(1) ? c.sx : near(c.sx);
                c.ey = (c.ex == c.sx) ? near(c.sy) : c.sy;
            end
            default: begin
                c.ex = near(c.sx);
                c.ey = near(c.sy);
            end
        endcase
        len = int'(c.ex) - int'(c.sx);
        if (len < 0) begin
            len = -len;
        end
        n = int'(c.ey) - int'(c.sy);
        if (n < 0) begin
            n = -n;
        end
        if (n > len) begin
            len = n;
        end
        len = len + 1;
        send_command(c);
        n = len;
        if (n > 60 || $urandom_range(99) < 15) begin
            n = $urandom_range((len > 60) ? 60 : len);
        end
        if ($urandom_range(99) < 20) begin
            n = n + $urandom_range(1, 3);
        end
        send_steps(n);
    endtask

    initial begin
        board = new();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed lines
        send_steps(1);                                       // step while idle
        send_start(12'd0, 12'd0, 12'd0, 12'd0, 24'h000000);  // single point
        send_steps(2);
        send_start(12'd4095, 12'd4095, 12'd4092, 12'd4095, 24'hffffff);
        send_steps(4);
        send_start(12'd0, 12'd0, 12'd4, 12'd2, 24'h5a3c96);  // x major, minor up
        send_steps(5);
        send_start(12'd10, 12'd10, 12'd7, 12'd13, 24'ha5c369); // tie, minor down
        send_steps(2);
        send_start(12'd4095, 12'd0, 12'd0, 12'd4095, 24'h0f0f0f); // replaces running line
        send_steps(2);
        send_start(12'd9, 12'd9, 12'd9, 12'd5, 24'hf0f0f0);  // vertical, y decreasing
        send_steps(5);

        beats_used = 0;
        while (beats_used < 500) begin
            phase = (beats_used * 3) / 500;
            if ($urandom_range(99) < 10) begin
                send_command(random_command());
            end else begin
                random_line();
            end
        end
        phase = 2;
        i_valid <= 1'b0;

        while (board.pending() > 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("line_rasterizer_core: match");
        end else begin
            $display("line_rasterizer_core: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
design/lr_pkg.sv
design/lr_setup.sv
design/lr_step.sv
design/line_rasterizer_core.sv
tb/testbench.sv
